// ===== hw/rtl/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types, constants and helpers for the calendar day difference block.
// ----------------------------------------------------------------------------
package cdd_pkg;

   localparam int COUNT_BITS = 20;
   localparam int YEAR_BITS  = 14;
   localparam int MONTH_BITS = 4;
   localparam int DAY_BITS   = 5;
   localparam int REQ_BITS   = ((2 * (YEAR_BITS + MONTH_BITS + DAY_BITS) + 7) / 8) * 8;
   localparam int RSP_BITS   = ((COUNT_BITS + 2 + 7) / 8) * 8;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WALK_LIMIT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AGE_LIMIT  = 2'd1;

   localparam logic [COUNT_BITS-1:0] WALK_LIMIT_RESET = COUNT_BITS'(1048575);
   localparam logic [COUNT_BITS-1:0] AGE_LIMIT_RESET  = COUNT_BITS'(43830);

   // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for 14-bit y
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   localparam int          PROD_BITS    = 27;
   localparam int          CENT_BITS    = 8;
   localparam int          REM_BITS     = 7;

   localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;
   localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic step;
      logic give_up;
   } cmd_type;

   typedef struct packed {
      logic at_end;
      logic at_limit;
   } status_type;

   // Month length; months outside 1..12 count as 31 days.
   function automatic logic [DAY_BITS-1:0] month_days(
      input logic [MONTH_BITS-1:0] month,
      input logic                  leap
   );
      logic [DAY_BITS-1:0] days;
      case (month)
         MONTH_FEB: days = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ===== hw/rtl/cdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdd_ctrl
// Sequencer: load, prepare year residues, walk one day per cycle, deliver.
// ----------------------------------------------------------------------------
module cdd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  cdd_pkg::status_type status,
   output cdd_pkg::cmd_type    cmd
);

   cdd_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         cdd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = cdd_pkg::ST_PREP;
            end
         end
         cdd_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = cdd_pkg::ST_WALK;
         end
         cdd_pkg::ST_WALK: begin
            if (status.at_end) begin
               state_in = cdd_pkg::ST_DONE;
            end else if (status.at_limit) begin
               cmd.give_up = 1'b1;
               state_in    = cdd_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         cdd_pkg::ST_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = cdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/cdd_datapath.sv =====
// ----------------------------------------------------------------------------
// cdd_datapath
// Day cursor, step counter, year residues mod 100, limit registers.
// ----------------------------------------------------------------------------
module cdd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cdd_pkg::REQ_BITS-1:0]        req_tdata,
   input  logic                                csr_valid,
   input  logic [cdd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cdd_pkg::COUNT_BITS-1:0]      csr_data,
   input  cdd_pkg::cmd_type                    cmd,
   output cdd_pkg::status_type                 status,
   output logic [cdd_pkg::RSP_BITS-1:0]        rsp_tdata
);

   logic [cdd_pkg::YEAR_BITS-1:0]  year_ff, year_in, end_year_ff;
   logic [cdd_pkg::MONTH_BITS-1:0] month_ff, month_in, end_month_ff;
   logic [cdd_pkg::DAY_BITS-1:0]   day_ff, day_in, end_day_ff;
   logic [cdd_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [cdd_pkg::PROD_BITS-1:0]  prod_ff;
   logic [cdd_pkg::CENT_BITS-1:0]  cent_ff, cent_in;
   logic [cdd_pkg::REM_BITS-1:0]   rem_ff, rem_in;
   logic                           gave_up_ff, gave_up_in;
   logic [cdd_pkg::COUNT_BITS-1:0] walk_limit_ff, age_limit_ff;

   logic                           leap;
   logic [cdd_pkg::DAY_BITS:0]     day_next;
   logic [cdd_pkg::DAY_BITS-1:0]   mdays;
   logic [cdd_pkg::CENT_BITS-1:0]  prep_cent;
   logic [cdd_pkg::YEAR_BITS-1:0]  prep_rem;
   logic                           over_age;

   assign leap  = (year_ff[1:0] == 2'd0) && ((rem_ff != '0) || (cent_ff[1:0] == 2'd0));
   assign mdays = cdd_pkg::month_days(month_ff, leap);
   assign day_next = {1'b0, day_ff} + 6'd1;

   assign prep_cent = prod_ff[cdd_pkg::PROD_BITS-1:cdd_pkg::DIV100_SHIFT];
   assign prep_rem  = year_ff - (cdd_pkg::YEAR_BITS'(prep_cent) * 14'd100);

   always_comb begin
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      count_in   = count_ff;
      cent_in    = cent_ff;
      rem_in     = rem_ff;
      gave_up_in = gave_up_ff;
      if (cmd.load) begin
         year_in    = req_tdata[13:0];
         month_in   = req_tdata[17:14];
         day_in     = req_tdata[22:18];
         count_in   = '0;
         gave_up_in = 1'b0;
      end
      if (cmd.prep) begin
         cent_in = prep_cent;
         rem_in  = prep_rem[cdd_pkg::REM_BITS-1:0];
      end
      if (cmd.give_up) begin
         gave_up_in = 1'b1;
      end
      if (cmd.step) begin
         count_in = count_ff + cdd_pkg::COUNT_BITS'(1);
         if (day_next > {1'b0, mdays}) begin
            day_in = 5'd1;
            if (month_ff >= cdd_pkg::MONTH_DEC) begin
               month_in = cdd_pkg::MONTH_JAN;
               year_in  = year_ff + cdd_pkg::YEAR_BITS'(1);
               if (year_ff == '1) begin
                  cent_in = '0;
                  rem_in  = '0;
               end else if (rem_ff == 7'd99) begin
                  cent_in = cent_ff + cdd_pkg::CENT_BITS'(1);
                  rem_in  = '0;
               end else begin
                  rem_in = rem_ff + cdd_pkg::REM_BITS'(1);
               end
            end else begin
               month_in = month_ff + cdd_pkg::MONTH_BITS'(1);
            end
         end else begin
            day_in = day_next[cdd_pkg::DAY_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff    <= '0;
         month_ff   <= cdd_pkg::MONTH_JAN;
         day_ff     <= 5'd1;
         count_ff   <= '0;
         cent_ff    <= '0;
         rem_ff     <= '0;
         gave_up_ff <= 1'b0;
      end else begin
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         count_ff   <= count_in;
         cent_ff    <= cent_in;
         rem_ff     <= rem_in;
         gave_up_ff <= gave_up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         end_year_ff  <= req_tdata[36:23];
         end_month_ff <= req_tdata[40:37];
         end_day_ff   <= req_tdata[45:41];
         prod_ff      <= cdd_pkg::PROD_BITS'(req_tdata[13:0]) *
                         cdd_pkg::PROD_BITS'(cdd_pkg::DIV100_MUL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_limit_ff <= cdd_pkg::WALK_LIMIT_RESET;
         age_limit_ff  <= cdd_pkg::AGE_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cdd_pkg::CSR_WALK_LIMIT: walk_limit_ff <= csr_data;
            cdd_pkg::CSR_AGE_LIMIT:  age_limit_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign status.at_end   = (day_ff == end_day_ff) && (month_ff == end_month_ff) &&
                            (year_ff == end_year_ff);
   assign status.at_limit = (count_ff >= walk_limit_ff);

   assign over_age  = (count_ff >= age_limit_ff);
   assign rsp_tdata = cdd_pkg::RSP_BITS'({gave_up_ff, over_age, count_ff});

endmodule

// ===== hw/rtl/calendar_day_difference.sv =====
// ----------------------------------------------------------------------------
// calendar_day_difference
// Counts Gregorian days from a start date to an end date by day stepping.
//
//   channel | dir | handshake               | payload
//   req     | in  | req_tvalid/req_tready   | start and end dates
//   rsp     | out | rsp_tvalid/rsp_tready   | day count and flags
//   csr     | in  | csr_valid/csr_ready     | csr_index, csr_data
//
// A transaction passes through the idle state that accepts it, a prepare
// state that forms year mod 100, one walk step per day counted plus one
// closing compare, and a done state presenting the result.
// A walk that gives up stops at day_count = walk_limit. A low rsp_tready
// holds the result; req_tready is high only while idle; csr writes always taken.
// Reset is synchronous; limits return to walk 1048575, age 43830.
// ----------------------------------------------------------------------------
module calendar_day_difference (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_year[13:0], start_month[17:14], start_day[22:18],
   // end_year[36:23], end_month[40:37], end_day[45:41], zero pad
   input  logic [cdd_pkg::REQ_BITS-1:0]     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // day_count[19:0], over_age_limit[20], gave_up[21], zero pad
   output logic [cdd_pkg::RSP_BITS-1:0]     rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cdd_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [cdd_pkg::COUNT_BITS-1:0]   csr_data
);

   cdd_pkg::cmd_type    cmd;
   cdd_pkg::status_type status;

   assign csr_ready = 1'b1;

   cdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cdd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== tb/calendar_day_difference_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_day_difference_tb
// Self-checking bench for the day-stepping date difference block. Date pairs
// go in on the req stream, and an internal day walker predicts each count and
// its flags. Every rsp transaction is compared against the oldest prediction.
// Limits are reprogrammed between phases while the block is idle. Both
// streams stall at random, except during one quiet phase.
// ----------------------------------------------------------------------------
module calendar_day_difference_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [cdd_pkg::DAY_BITS-1:0]   end_day;
      logic [cdd_pkg::MONTH_BITS-1:0] end_month;
      logic [cdd_pkg::YEAR_BITS-1:0]  end_year;
      logic [cdd_pkg::DAY_BITS-1:0]   start_day;
      logic [cdd_pkg::MONTH_BITS-1:0] start_month;
      logic [cdd_pkg::YEAR_BITS-1:0]  start_year;
   } date_pair_type;

   typedef struct packed {
      logic                           gave_up;
      logic                           over_age_limit;
      logic [cdd_pkg::COUNT_BITS-1:0] day_count;
   } day_diff_type;

   localparam int PAIR_BITS = $bits(date_pair_type);

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [cdd_pkg::REQ_BITS-1:0]     req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [cdd_pkg::RSP_BITS-1:0]     rsp_tdata;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [cdd_pkg::CSR_IDX_BITS-1:0] csr_index  = cdd_pkg::CSR_WALK_LIMIT;
   logic [cdd_pkg::COUNT_BITS-1:0]   csr_data   = '0;

   logic [cdd_pkg::COUNT_BITS-1:0] walk_limit_q = cdd_pkg::WALK_LIMIT_RESET;
   logic [cdd_pkg::COUNT_BITS-1:0] age_limit_q  = cdd_pkg::AGE_LIMIT_RESET;

   day_diff_type day_diff_q[$];
   bit           calm = 1'b0;
   int unsigned  fails = 0;
   int unsigned  checked = 0;
   int unsigned  gave_up_seen = 0;
   int unsigned  over_age_seen = 0;
   int unsigned  settings_tried = 0;
   int unsigned  cycle_count = 0;

   calendar_day_difference dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic leap_year(logic [cdd_pkg::YEAR_BITS-1:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // months outside 1..12 walk as 31-day months
   function automatic int unsigned month_length(logic [cdd_pkg::MONTH_BITS-1:0] m,
                                                logic [cdd_pkg::YEAR_BITS-1:0] y);
      case (m)
         cdd_pkg::MONTH_FEB: return leap_year(y) ? 29 : 28;
         cdd_pkg::MONTH_APR, cdd_pkg::MONTH_JUN,
         cdd_pkg::MONTH_SEP, cdd_pkg::MONTH_NOV: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic day_diff_type predict_day_diff(date_pair_type p);
      logic [cdd_pkg::YEAR_BITS-1:0]  y;
      logic [cdd_pkg::MONTH_BITS-1:0] m;
      logic [cdd_pkg::DAY_BITS:0]     d;
      logic [cdd_pkg::COUNT_BITS-1:0] n;
      day_diff_type                   r;
      y = p.start_year;
      m = p.start_month;
      d = {1'b0, p.start_day};
      n = '0;
      r = '0;
      while (!r.gave_up && !(d[cdd_pkg::DAY_BITS-1:0] == p.end_day && m == p.end_month
                             && y == p.end_year)) begin
         if (n >= walk_limit_q) begin
            r.gave_up = 1'b1;
         end else begin
            n = n + cdd_pkg::COUNT_BITS'(1);
            d = d + 6'd1;
            if (d > month_length(m, y)) begin
               d = 6'd1;
               if (m >= cdd_pkg::MONTH_DEC) begin
                  m = cdd_pkg::MONTH_JAN;
                  y = y + cdd_pkg::YEAR_BITS'(1);
               end else begin
                  m = m + cdd_pkg::MONTH_BITS'(1);
               end
            end
         end
      end
      r.day_count = n;
      r.over_age_limit = (n >= age_limit_q);
      return r;
   endfunction

   function automatic date_pair_type make_pair(int unsigned sy, sm, sd, ey, em, ed);
      date_pair_type p;
      p.start_year  = sy[cdd_pkg::YEAR_BITS-1:0];
      p.start_month = sm[cdd_pkg::MONTH_BITS-1:0];
      p.start_day   = sd[cdd_pkg::DAY_BITS-1:0];
      p.end_year    = ey[cdd_pkg::YEAR_BITS-1:0];
      p.end_month   = em[cdd_pkg::MONTH_BITS-1:0];
      p.end_day     = ed[cdd_pkg::DAY_BITS-1:0];
      return p;
   endfunction

   // mostly real dates a few years apart, some reversed, some raw field noise
   function automatic date_pair_type random_date_pair(int unsigned year_span);
      date_pair_type p;
      date_pair_type q;
      int unsigned   sy;
      int unsigned   ey;
      int unsigned   sm;
      int unsigned   em;
      if ($urandom_range(99) < 15) begin
         p = date_pair_type'(PAIR_BITS'({$urandom, $urandom}));
      end else begin
         sy = $urandom_range(16383 - year_span);
         ey = sy + $urandom_range(year_span);
         sm = $urandom_range(1, 12);
         em = $urandom_range(1, 12);
         p = make_pair(sy, sm,
                       $urandom_range(1, month_length(cdd_pkg::MONTH_BITS'(sm),
                                                      cdd_pkg::YEAR_BITS'(sy))),
                       ey, em,
                       $urandom_range(1, month_length(cdd_pkg::MONTH_BITS'(em),
                                                      cdd_pkg::YEAR_BITS'(ey))));
         if ($urandom_range(99) < 12) begin
            q = p;
            p.start_year  = q.end_year;
            p.start_month = q.end_month;
            p.start_day   = q.end_day;
            p.end_year    = q.start_year;
            p.end_month   = q.start_month;
            p.end_day     = q.start_day;
         end
      end
      return p;
   endfunction

   task automatic send_dates(date_pair_type p);
      int unsigned gap;
      if (!calm && $urandom_range(99) < 12) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(cdd_pkg::REQ_BITS - PAIR_BITS){1'b0}}, p};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      day_diff_q.push_back(predict_day_diff(p));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (day_diff_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_limits(logic [cdd_pkg::COUNT_BITS-1:0] walk,
                             logic [cdd_pkg::COUNT_BITS-1:0] age);
      csr_index <= cdd_pkg::CSR_WALK_LIMIT;
      csr_data  <= walk;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      walk_limit_q = walk;
      csr_index <= cdd_pkg::CSR_AGE_LIMIT;
      csr_data  <= age;
      do @(posedge clock); while (!csr_ready);
      age_limit_q = age;
      csr_valid <= 1'b0;
      settings_tried++;
   endtask

   // reset limits: leap rules, rollovers, odd cursor fields, long walks
   task automatic test_calendar_rules();
      send_dates(make_pair(2024, 3, 15, 2024, 3, 15));
      send_dates(make_pair(0, 0, 0, 0, 0, 0));
      send_dates(make_pair(16383, 15, 31, 16383, 15, 31));
      send_dates(make_pair(2023, 12, 31, 2024, 1, 1));
      send_dates(make_pair(2024, 2, 28, 2024, 3, 1));
      send_dates(make_pair(1900, 2, 28, 1900, 3, 1));
      send_dates(make_pair(2000, 2, 28, 2000, 3, 1));
      send_dates(make_pair(2001, 4, 31, 2001, 5, 1));
      send_dates(make_pair(2001, 0, 30, 2001, 1, 1));
      send_dates(make_pair(2001, 13, 31, 2002, 1, 1));
      send_dates(make_pair(2001, 15, 0, 2002, 1, 1));
      send_dates(make_pair(2001, 6, 0, 2001, 6, 1));
      send_dates(make_pair(16383, 12, 31, 0, 1, 1));
      send_dates(make_pair(9999, 12, 31, 10000, 1, 1));
      send_dates(make_pair(0, 1, 1, 0, 12, 31));
      send_dates(make_pair(2000, 1, 1, 2120, 1, 1));
      send_dates(make_pair(2000, 1, 1, 2120, 1, 2));
      wait_for_results();
   endtask

   task automatic test_tight_walk_limit();
      set_limits(1, 0);
      send_dates(make_pair(2024, 7, 4, 2024, 7, 4));
      send_dates(make_pair(2024, 7, 4, 2024, 7, 5));
      send_dates(make_pair(2024, 7, 4, 2024, 7, 6));
      send_dates(make_pair(2024, 1, 2, 2024, 1, 1));
      wait_for_results();
   endtask

   task automatic test_zero_walk_limit();
      set_limits(0, {cdd_pkg::COUNT_BITS{1'b1}});
      send_dates(make_pair(1999, 9, 9, 1999, 9, 9));
      send_dates(make_pair(1999, 9, 9, 1999, 9, 10));
      wait_for_results();
   endtask

   task automatic test_unreachable_end();
      set_limits(400, 200);
      send_dates(make_pair(2024, 5, 10, 2024, 5, 0));
      send_dates(make_pair(2024, 11, 1, 2024, 0, 5));
      send_dates(make_pair(2024, 11, 1, 2025, 13, 1));
      send_dates(make_pair(2024, 3, 1, 2024, 4, 31));
      send_dates(make_pair(2024, 3, 1, 2023, 3, 1));
      wait_for_results();
   endtask

   task automatic test_random_dates(int unsigned count, int unsigned walk, int unsigned age,
                                    int unsigned year_span, bit quiet);
      calm = quiet;
      set_limits(walk[cdd_pkg::COUNT_BITS-1:0], age[cdd_pkg::COUNT_BITS-1:0]);
      repeat (count) send_dates(random_date_pair(year_span));
      wait_for_results();
      calm = 1'b0;
   endtask

   task automatic test_restore_defaults();
      set_limits(cdd_pkg::WALK_LIMIT_RESET, cdd_pkg::AGE_LIMIT_RESET);
      send_dates(make_pair(2024, 1, 1, 2024, 12, 31));
      send_dates(make_pair(1600, 2, 29, 1600, 3, 1));
      wait_for_results();
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin : check_results
      day_diff_type want;
      day_diff_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[$bits(day_diff_type)-1:0];
         if (day_diff_q.size() == 0) begin
            $error("rsp transaction with no pending date pair: %h", rsp_tdata);
            fails++;
         end else begin
            want = day_diff_q.pop_front();
            if (seen.day_count !== want.day_count) begin
               $error("day_count: expected %0d, got %0d", want.day_count, seen.day_count);
               fails++;
            end
            if (seen.over_age_limit !== want.over_age_limit) begin
               $error("over_age_limit: expected %0b, got %0b",
                      want.over_age_limit, seen.over_age_limit);
               fails++;
            end
            if (seen.gave_up !== want.gave_up) begin
               $error("gave_up: expected %0b, got %0b", want.gave_up, seen.gave_up);
               fails++;
            end
            checked++;
            gave_up_seen += want.gave_up;
            over_age_seen += want.over_age_limit;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("calendar_day_difference regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_calendar_rules();
      test_tight_walk_limit();
      test_zero_walk_limit();
      test_unreachable_end();
      test_random_dates(25, 4000, $urandom_range(3000), 8, 1'b1);
      test_random_dates(25, $urandom_range(1, 3000), $urandom_range(4000), 6, 1'b0);
      test_random_dates(25, $urandom_range(1, 60), $urandom_range(60), 0, 1'b0);
      test_restore_defaults();
      repeat (8) @(posedge clock);
      $display("%0d date pairs checked over %0d limit settings in %0d cycles",
               checked, settings_tried, cycle_count);
      $display("%0d walks gave up, %0d counts reached the age limit",
               gave_up_seen, over_age_seen);
      if (fails == 0) begin
         $display("calendar_day_difference regression: pass");
      end else begin
         $display("calendar_day_difference regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/cdd_pkg.sv
hw/rtl/cdd_ctrl.sv
hw/rtl/cdd_datapath.sv
hw/rtl/calendar_day_difference.sv
tb/calendar_day_difference_tb.sv
